/* rtl/tksel_pkg.sv */
// package with the entry type, cell control struct and size constants of the top-k selector
`default_nettype none
package tksel_pkg;

    localparam int MAX_KEPT = 256;
    localparam int DIST_W   = 32;
    localparam int IDENT_W  = 32;
    localparam int K_W      = 9;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);
    localparam int CMP_W    = (K_W > CNT_W) ? K_W : CNT_W;

    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_POP   = 1'b1;

    localparam logic [K_W-1:0] K_USED_RESET = K_W'(256);

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [IDENT_W-1:0] ident;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic grow;
        logic pop;
    } t_cell_ctrl;

    typedef struct packed {
        t_entry ent;
        logic   valid;
        logic   le;
    } t_cell_link;

endpackage
`default_nettype wire

/* rtl/tksel_cell.sv */
// one rank cell of the sorted chain: holds one entry and trades it with its neighbours
`default_nettype none
module tksel_cell (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire tksel_pkg::t_cell_ctrl       i_ctrl,
    input  wire [tksel_pkg::DIST_W-1:0]      i_cand_distance,
    input  wire [tksel_pkg::IDENT_W-1:0]     i_cand_ident,
    input  wire tksel_pkg::t_cell_link       i_left,
    input  wire tksel_pkg::t_cell_link       i_right,
    output tksel_pkg::t_cell_link            o_link,
    output logic                             o_last_gt
);
    import tksel_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_valid;
    logic   n_valid;
    logic   w_le;

    assign w_le      = r_valid && (r_ent.distance <= i_cand_distance);
    assign o_link    = '{ent: r_ent, valid: r_valid, le: w_le};
    assign o_last_gt = r_valid && !i_right.valid && !w_le;

    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        if (i_ctrl.pop) begin
            n_ent   = i_right.ent;
            n_valid = i_right.valid;
        end else if (i_ctrl.ins) begin
            if (!w_le) begin
                if (i_left.le) begin
                    n_ent.distance = i_cand_distance;
                    n_ent.ident    = i_cand_ident;
                end else begin
                    n_ent = i_left.ent;
                end
            end
            if (i_ctrl.grow) begin
                n_valid = r_valid | i_left.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

/* rtl/top_k_smallest_selector_core.sv */
// top level of the top-k selector: sorted chain of cells, count, and result register
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_func, i_cand_distance, i_cand_ident
//  out     | o_res_valid | i_res_stall | o_out_ident, o_out_distance, o_out_valid, o_out_last
//  cfg     | i_cfg_we    | -           | i_cfg_data (k_used)
//
// one beat per cycle while the input is not stalled: each cell compares the broadcast
// candidate in the same cycle, so an offer or a pop takes effect at the accepting edge;
// a pop's result is registered at that edge and shows on the output in the next cycle.
// synchronous reset clears the count, cell valid bits and the result valid flag; k_used
// returns to 256. the input stalls only while a result is held and the output is stalled.
`default_nettype none
module top_k_smallest_selector_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_func,
    input  wire [tksel_pkg::DIST_W-1:0]      i_cand_distance,
    input  wire [tksel_pkg::IDENT_W-1:0]     i_cand_ident,
    input  wire                              i_cfg_we,
    input  wire [tksel_pkg::K_W-1:0]         i_cfg_data,
    output logic                             o_res_valid,
    input  wire                              i_res_stall,
    output logic [tksel_pkg::IDENT_W-1:0]    o_out_ident,
    output logic [tksel_pkg::DIST_W-1:0]     o_out_distance,
    output logic                             o_out_valid,
    output logic                             o_out_last
);
    import tksel_pkg::*;

    logic [K_W-1:0]     r_k_used;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_res_vld;
    logic [IDENT_W-1:0] r_ident;
    logic [DIST_W-1:0]  r_dist;
    logic               r_ov;
    logic               r_last;

    t_cell_link         w_link [MAX_KEPT+2];
    t_cell_link         w_head;
    t_cell_link         w_tail;
    logic [MAX_KEPT-1:0] w_last_gt;
    t_cell_ctrl         w_ctrl;

    logic               w_acc;
    logic               w_pop;
    logic               w_offer;
    logic               w_taken;
    logic [CMP_W-1:0]   w_k_ext;
    logic [CMP_W-1:0]   w_cap;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic               w_room;
    logic               w_replace;
    logic               w_empty;

    assign o_in_stall = r_res_vld && i_res_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_pop      = w_acc && (i_func == FUNC_POP);
    assign w_offer    = w_acc && (i_func == FUNC_OFFER);
    assign w_taken    = r_res_vld && !i_res_stall;

    assign w_k_ext    = CMP_W'(r_k_used);
    assign w_cap      = (w_k_ext > CMP_W'(MAX_KEPT)) ? CMP_W'(MAX_KEPT) : w_k_ext;
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_empty    = (r_count == '0);
    assign w_room     = w_cnt_ext < w_cap;
    assign w_replace  = !w_empty && (|w_last_gt);

    always_comb begin
        w_ctrl.pop  = w_pop && !w_empty;
        w_ctrl.grow = w_offer && w_room;
        w_ctrl.ins  = w_offer && (w_room || w_replace);
    end

    assign w_head = '{ent: '0, valid: 1'b1, le: 1'b1};
    assign w_tail = '{ent: '0, valid: 1'b0, le: 1'b0};

    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        tksel_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl),
            .i_cand_distance (i_cand_distance),
            .i_cand_ident    (i_cand_ident),
            .i_left          (w_link[g]),
            .i_right         (w_link[g+2]),
            .o_link          (w_link[g+1]),
            .o_last_gt       (w_last_gt[g])
        );
    end
    assign w_link[0]          = w_head;
    assign w_link[MAX_KEPT+1] = w_tail;

    always_comb begin
        n_count = r_count;
        if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end else if (w_ctrl.grow) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ident <= w_empty ? '0 : w_link[1].ent.ident;
            r_dist  <= w_empty ? '0 : w_link[1].ent.distance;
            r_ov    <= !w_empty;
            r_last  <= (r_count == CNT_W'(1));
        end
        if (!i_rst_n) begin
            r_k_used  <= K_USED_RESET;
            r_count   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k_used <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_pop) begin
                r_res_vld <= 1'b1;
            end else if (w_taken) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    assign o_res_valid    = r_res_vld;
    assign o_out_ident    = r_ident;
    assign o_out_distance = r_dist;
    assign o_out_valid    = r_ov;
    assign o_out_last     = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(MAX_KEPT))
        else $error("kept count above capacity");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_link[1].valid)
        else $error("head cell valid disagrees with count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_empty) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement count");

    a_grow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_offer && w_room) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("offer with room did not increment count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_empty) |=> (!r_ov && r_ident == '0 && r_dist == '0 && !r_last))
        else $error("pop on empty store gave non-zero result");
`endif

endmodule
`default_nettype wire

/* tb/sv/tksel_tb_pkg.sv */
`timescale 1ns / 100ps
// scoreboard package: ordered-store predictor of the top-k selector and pop result checks
package tksel_tb_pkg;
    import tksel_pkg::*;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [DIST_W-1:0]  distance;
        logic               valid;
        logic               last;
    } t_pop_beat;

    class nearest_scoreboard;
        t_entry         kept[$];
        t_pop_beat      due[$];
        logic [K_W-1:0] k_used;
        int             errors;
        int             checked;
        int             empty_pops;

        function new();
            k_used     = K_USED_RESET;
            errors     = 0;
            checked    = 0;
            empty_pops = 0;
        endfunction

        function void set_k(logic [K_W-1:0] k);
            k_used = k;
        endfunction

        function int held();
            return kept.size();
        endfunction

        function int pending();
            return due.size();
        endfunction

        // ascending distance, ties after every entry of equal distance
        function void keep(t_entry e);
            int pos;
            pos = 0;
            if (kept.size() >= MAX_KEPT) return;
            while (pos < kept.size() && kept[pos].distance <= e.distance) pos++;
            kept.insert(pos, e);
        endfunction

        function void note_beat(logic func, logic [DIST_W-1:0] d, logic [IDENT_W-1:0] id);
            int        cap;
            t_entry    e;
            t_pop_beat r;
            cap = (k_used > MAX_KEPT) ? MAX_KEPT : int'(k_used);
            e.distance = d;
            e.ident    = id;
            if (func == FUNC_OFFER) begin
                if (kept.size() < cap) begin
                    keep(e);
                end else if (kept.size() > 0 && d < kept[kept.size()-1].distance) begin
                    void'(kept.pop_back());
                    keep(e);
                end
            end else begin
                r = '0;
                if (kept.size() != 0) begin
                    e          = kept.pop_front();
                    r.ident    = e.ident;
                    r.distance = e.distance;
                    r.valid    = 1'b1;
                    r.last     = (kept.size() == 0);
                end else begin
                    empty_pops++;
                end
                due = {due, r};
            end
        endfunction

        function void check_beat(logic [IDENT_W-1:0] ident, logic [DIST_W-1:0] distance,
                                 logic valid, logic last);
            t_pop_beat r;
            if (due.size() == 0) begin
                $error("result beat with nothing due: ident %h distance %h", ident, distance);
                errors++;
                return;
            end
            r = due.pop_front();
            checked++;
            if (ident !== r.ident) begin
                $error("out_ident: expected %h, got %h", r.ident, ident);
                errors++;
            end
            if (distance !== r.distance) begin
                $error("out_distance: expected %h, got %h", r.distance, distance);
                errors++;
            end
            if (valid !== r.valid) begin
                $error("out_valid: expected %b, got %b", r.valid, valid);
                errors++;
            end
            if (last !== r.last) begin
                $error("out_last: expected %b, got %b", r.last, last);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/top_k_smallest_selector_core_tb.sv */
`timescale 1ns / 100ps
// testbench top: drives offers, pops and k_used writes into the top-k selector and checks pops
module top_k_smallest_selector_core_tb;
    import tksel_pkg::*;
    import tksel_tb_pkg::*;

    localparam int TARGET_BEATS = 1550;
    localparam int MAX_GAP      = 11;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 i_func          = FUNC_OFFER;
    logic [DIST_W-1:0]    i_cand_distance = '0;
    logic [IDENT_W-1:0]   i_cand_ident    = '0;
    logic                 i_cfg_we        = 1'b0;
    logic [K_W-1:0]       i_cfg_data      = '0;
    logic                 i_res_stall     = 1'b0;
    wire                  o_in_stall;
    wire                  o_res_valid;
    wire  [IDENT_W-1:0]   o_out_ident;
    wire  [DIST_W-1:0]    o_out_distance;
    wire                  o_out_valid;
    wire                  o_out_last;

    nearest_scoreboard sb = new();

    int beats_sent    = 0;
    int idle_cycles   = 0;
    int k_settings    = 0;
    int tx_max_gap    = 0;
    int rx_max_gap    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int rx_wait       = 0;

    top_k_smallest_selector_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_cand_distance (i_cand_distance),
        .i_cand_ident    (i_cand_ident),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_out_ident     (o_out_ident),
        .o_out_distance  (o_out_distance),
        .o_out_valid     (o_out_valid),
        .o_out_last      (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : beat_monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_beat(i_func, i_cand_distance, i_cand_ident);
                moved = 1'b1;
            end
            if (o_res_valid && !i_res_stall) begin
                sb.check_beat(o_out_ident, o_out_distance, o_out_valid, o_out_last);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // receiver: random wait after each result beat, plus the long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            i_res_stall <= 1'b0;
        end else begin
            if (holds_served != hold_requests) begin
                holds_served++;
                rx_wait = LONG_HOLD;
            end else if (o_res_valid && !i_res_stall) begin
                rx_wait = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_res_stall <= (rx_wait > 0);
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("top_k_smallest_selector_core verification failed");
        $finish;
    end

    task automatic send_beat(logic func, logic [DIST_W-1:0] d, logic [IDENT_W-1:0] id);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= func;
        i_cand_distance <= d;
        i_cand_ident    <= id;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    task automatic write_k(logic [K_W-1:0] k);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_k(k);
        k_settings++;
    endtask

    // a query: offers, then pops until the store is drained, optionally one more
    task automatic run_query(int offers, bit ties, int extra_pops);
        repeat (offers)
            send_beat(FUNC_OFFER, ties ? DIST_W'($urandom_range(0, 15)) : $urandom, $urandom);
        repeat (sb.held() + extra_pops) send_beat(FUNC_POP, $urandom, $urandom);
    endtask

    task automatic run_noise(int n, bit ties);
        repeat (n)
            send_beat(1'($urandom_range(0, 1)),
                      ties ? DIST_W'($urandom_range(0, 15)) : $urandom, $urandom);
    endtask

    initial begin : stimulus
        int             phase;
        int             r;
        logic [K_W-1:0] k;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, field extremes, equal distances
        send_beat(FUNC_POP, '0, '0);
        send_beat(FUNC_OFFER, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(FUNC_OFFER, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(FUNC_OFFER, 32'd5, 32'd1);
        send_beat(FUNC_OFFER, 32'd5, 32'd2);
        send_beat(FUNC_OFFER, 32'd5, 32'd3);
        repeat (6) send_beat(FUNC_POP, '1, '1);

        // single slot: equal offer dropped, smaller one replaces
        write_k(K_W'(1));
        send_beat(FUNC_OFFER, 32'd10, 32'd7);
        send_beat(FUNC_OFFER, 32'd10, 32'd8);
        send_beat(FUNC_OFFER, 32'd3, 32'd9);
        send_beat(FUNC_POP, '0, '0);
        send_beat(FUNC_POP, '0, '0);

        // nothing kept
        write_k(K_W'(0));
        send_beat(FUNC_OFFER, 32'd1, 32'd1);
        send_beat(FUNC_POP, '0, '0);

        // capacity above the store, then lowered below the fill
        write_k(K_W'(511));
        send_beat(FUNC_OFFER, 32'd20, 32'hA5A5_A5A5);
        send_beat(FUNC_OFFER, 32'd30, 32'h5A5A_5A5A);
        send_beat(FUNC_OFFER, 32'd40, 32'd4);
        write_k(K_W'(2));
        send_beat(FUNC_OFFER, 32'd25, 32'd5);
        send_beat(FUNC_OFFER, 32'd50, 32'd6);
        repeat (3) send_beat(FUNC_POP, '0, '0);

        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            r = $urandom_range(0, 9);
            case (r)
                0: k = K_W'(0);
                1: k = K_W'(1);
                2: k = K_W'(MAX_KEPT);
                3: k = K_W'(511);
                4: k = K_W'($urandom_range(257, 510));
                default: k = K_W'($urandom_range(2, 12));
            endcase
            tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if (phase == 0) begin
                write_k(K_W'(MAX_KEPT));
                run_query(300, 1'b0, 1);
            end else if (phase == 1) begin
                // receiver holds off while offers and pops keep coming
                tx_max_gap = 0;
                write_k(K_W'(16));
                repeat (16) send_beat(FUNC_OFFER, $urandom, $urandom);
                hold_requests++;
                run_noise(24, 1'b0);
                run_query(0, 1'b0, 1);
            end else begin
                write_k(k);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 4) == 0)
                        run_noise($urandom_range(4, 20), 1'($urandom_range(0, 1)));
                    else
                        run_query($urandom_range(0, 24), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 1));
                end
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d input beats over %0d k_used settings, %0d pop results checked",
                 beats_sent, k_settings, sb.checked);
        $display("%0d pops hit an empty store, %0d long receiver hold-off(s)",
                 sb.empty_pops, holds_served);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("top_k_smallest_selector_core verification clean");
        else
            $display("top_k_smallest_selector_core verification failed");
        $finish;
    end

endmodule

/* top_k_smallest_selector_core.f */
rtl/tksel_pkg.sv
rtl/tksel_cell.sv
rtl/top_k_smallest_selector_core.sv
tb/sv/tksel_tb_pkg.sv
tb/sv/top_k_smallest_selector_core_tb.sv
